// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the chain walker RTL.
// Checks compile only when SYNTH is not defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/f12w_pkg.sv =====
// Types and constants for the FAT12 cluster chain walker.
// No dependencies.
package f12w_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_STEP  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CB,
    S_OFF,
    S_ROOT,
    S_EMIT
  } state_t;

  localparam logic CFG_SECTOR_BYTES        = 1'b0;
  localparam logic CFG_SECTORS_PER_CLUSTER = 1'b1;

  localparam logic [11:0] CHAIN_END = 12'hFF8;
  localparam logic [19:0] SEG_MAX   = 20'hFFFFF;

  localparam int MAC_A_W = 21;
  localparam int MAC_B_W = 12;
  localparam int MAC_R_W = 32;

  // Operands of the shared multiply-accumulate unit
  typedef struct packed {
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
    logic [MAC_R_W-1:0] acc;
  } mac_op_t;

  function automatic logic chain_active(input logic [11:0] c);
    return (c >= 12'd2) && (c < CHAIN_END);
  endfunction

endpackage

// ===== hdl/f12w_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module f12w_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/f12w_mac.sv =====
// Shared multiply-accumulate unit: r <= a * b + acc, one pass per cycle.
// Depends on f12w_pkg.
module f12w_mac (
  input  logic                                clk,
  input  f12w_pkg::mac_op_t                   op,
  output logic [f12w_pkg::MAC_R_W-1:0]        r
);

  logic [f12w_pkg::MAC_A_W+f12w_pkg::MAC_B_W-1:0] prod;

  assign prod = op.a * op.b;

  always_ff @(posedge clk) begin
    r <= prod[f12w_pkg::MAC_R_W-1:0] + op.acc;
  end

endmodule

// ===== hdl/fat12_cluster_chain_walker_core.sv =====
// Top level of the FAT12 cluster chain walker: sequencer, table store, chain state.
// Depends on f12w_pkg, f12w_ram, f12w_mac and assert_macros.svh.
//
// Usage: an item transfers at a clock edge with start high and busy low.
// action selects a table byte load, a chain start or a chain step. Loads and
// starts take effect at the transfer edge and leave busy low. A step raises
// busy and produces exactly one result, marked by a one-cycle done strobe:
// in S_EMIT after S_CB, S_OFF and S_ROOT for an active chain (the shared multiplier
// makes three passes, cluster size, cluster offset, root area, while the two
// table bytes are read from the store), and in the cycle after the transfer
// for an inactive chain. busy drops in the cycle after done. The receiver cannot
// stall; a result is valid while done is high.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
// edge; they are to be made only while busy is low, which the block does not enforce.
// Reset clears the chain (no active cluster, zero bytes left) and restores
// 512 bytes per sector and one sector per cluster. The table store is not
// cleared; it must be loaded before a chain walks through it.
`include "assert_macros.svh"
module fat12_cluster_chain_walker_core #(
  parameter int TABLE_BYTES     = 8192,
  parameter int ROOT_END_SECTOR = 33
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [12:0] table_offset,
  input  logic [7:0]  table_byte,
  input  logic [11:0] start_cluster,
  input  logic [31:0] file_size,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  output logic        done,
  output logic        segment_valid,
  output logic [31:0] data_address,
  output logic [19:0] segment_bytes,
  output logic [11:0] this_cluster,
  output logic [11:0] following_cluster,
  output logic        last_segment
);

  localparam int AW = $clog2(TABLE_BYTES);

  f12w_pkg::state_t state, state_next;
  f12w_pkg::mac_op_t mac_op;

  logic [11:0] cur;
  logic [31:0] rem;
  logic [12:0] sb;
  logic [7:0]  spc;
  logic [20:0] cb;
  logic [7:0]  lo;
  logic [31:0] mac_r;
  logic [7:0]  rdata;
  logic [AW-1:0] raddr;
  logic          ram_we;
  logic          accept;
  logic [13:0]   c3;
  logic [12:0]   pos;
  logic [15:0]   entry_raw;
  logic [11:0]   entry;
  logic [31:0]   cb32;
  logic [31:0]   seg32;

  assign accept = start && !busy;

  // pos = cluster * 3 / 2
  assign c3  = {2'b00, cur} + {1'b0, cur, 1'b0};
  assign pos = c3[13:1];

  assign ram_we = accept && (f12w_pkg::action_t'(action) == f12w_pkg::ACT_LOAD) &&
                  (32'(table_offset) < 32'(TABLE_BYTES));

  always_comb begin
    raddr = AW'(pos);
    if (state == f12w_pkg::S_OFF) begin
      raddr = AW'(pos + 13'd1);
    end
  end

  f12w_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(table_offset)),
    .wdata (table_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    mac_op.a   = 21'(sb);
    mac_op.b   = 12'(spc);
    mac_op.acc = '0;
    case (state)
      f12w_pkg::S_OFF: begin
        mac_op.a = mac_r[20:0];
        mac_op.b = cur - 12'd2;
      end
      f12w_pkg::S_ROOT: begin
        mac_op.a   = 21'(sb);
        mac_op.b   = 12'(ROOT_END_SECTOR);
        mac_op.acc = mac_r;
      end
      default: begin
        mac_op.a = 21'(sb);
      end
    endcase
  end

  f12w_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .r   (mac_r)
  );

  // Table entry: odd clusters take the upper 12 bits of the 16-bit word
  assign entry_raw = {rdata, lo};
  assign entry     = cur[0] ? entry_raw[15:4] : entry_raw[11:0];

  assign cb32  = 32'(cb);
  assign seg32 = (cb32 < rem) ? cb32 : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= f12w_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      f12w_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start && (f12w_pkg::action_t'(action) == f12w_pkg::ACT_STEP)) begin
          state_next = f12w_pkg::chain_active(cur) ? f12w_pkg::S_CB : f12w_pkg::S_EMIT;
        end
      end
      f12w_pkg::S_CB:   state_next = f12w_pkg::S_OFF;
      f12w_pkg::S_OFF:  state_next = f12w_pkg::S_ROOT;
      f12w_pkg::S_ROOT: state_next = f12w_pkg::S_EMIT;
      f12w_pkg::S_EMIT: begin
        done       = 1'b1;
        state_next = f12w_pkg::S_IDLE;
      end
      default: state_next = f12w_pkg::S_IDLE;
    endcase
  end

  // Chain state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      rem <= '0;
      sb  <= 13'd512;
      spc <= 8'd1;
    end else begin
      if (cfg_write) begin
        if (cfg_index == f12w_pkg::CFG_SECTOR_BYTES) begin
          sb <= cfg_data;
        end else begin
          spc <= cfg_data[7:0];
        end
      end
      if (accept && (f12w_pkg::action_t'(action) == f12w_pkg::ACT_START)) begin
        cur <= start_cluster;
        rem <= file_size;
      end
      if (state == f12w_pkg::S_ROOT) begin
        cur <= entry;
        rem <= (rem > cb32) ? rem - cb32 : '0;
      end
    end
  end

  // Result fields; set in S_ROOT and cleared while idle
  always_ff @(posedge clk) begin
    if (state == f12w_pkg::S_OFF) begin
      cb <= mac_r[20:0];
      lo <= rdata;
    end
    if (state == f12w_pkg::S_IDLE) begin
      segment_valid     <= 1'b0;
      segment_bytes     <= '0;
      this_cluster      <= '0;
      following_cluster <= '0;
      last_segment      <= 1'b0;
    end
    if (state == f12w_pkg::S_ROOT) begin
      segment_valid     <= 1'b1;
      segment_bytes     <= (seg32 > 32'(f12w_pkg::SEG_MAX)) ? f12w_pkg::SEG_MAX : seg32[19:0];
      this_cluster      <= cur;
      following_cluster <= entry;
      last_segment      <= !f12w_pkg::chain_active(entry);
    end
  end

  assign data_address = segment_valid ? mac_r : '0;

  `ASSERT_IMPL(a_done_busy, clk, rst, done, busy)
  `ASSERT_NEXT(a_done_release, clk, rst, done, !busy)
  `ASSERT_NEXT(a_nostep_free, clk, rst,
    accept && (action != f12w_pkg::ACT_STEP), !busy && !done)
  `ASSERT_IMPL(a_valid_cluster, clk, rst, done && segment_valid,
    (this_cluster >= 12'd2) && (this_cluster < f12w_pkg::CHAIN_END))

endmodule

// ===== verif/fat12_cluster_chain_walker_core_tb.sv =====
// Testbench for fat12_cluster_chain_walker_core: table loads, chain starts and chain
// steps, directed then random, with every segment checked against a software walker.
// Depends on f12w_pkg and the core RTL.
module fat12_cluster_chain_walker_core_tb;

  localparam int TABLE_BYTES     = 8192;
  localparam int ROOT_END_SECTOR = 33;
  localparam logic [1:0] ACT_NONE = 2'd3;  // undefined action code, ignored by the block
  localparam int CYCLE_LIMIT     = 600000;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [19:0] nbytes;
    logic [11:0] cluster;
    logic [11:0] follow;
    logic        ends;
  } segment_t;

  class chain_scoreboard;
    logic [7:0]  fat_copy [TABLE_BYTES];
    logic [11:0] cur_cluster;
    logic [31:0] rem_bytes;
    logic [12:0] sector_bytes;
    logic [7:0]  sectors_per_cluster;
    segment_t    expected_segments [$];
    int          mismatches;

    function new();
      foreach (fat_copy[i]) fat_copy[i] = 8'h00;
      cur_cluster = '0;
      rem_bytes = '0;
      sector_bytes = 13'd512;
      sectors_per_cluster = 8'd1;
      mismatches = 0;
    endfunction

    function logic in_chain(logic [11:0] c);
      return (c >= 12'd2) && (c < f12w_pkg::CHAIN_END);
    endfunction

    function logic [31:0] cluster_size();
      return 32'(sector_bytes) * 32'(sectors_per_cluster);
    endfunction

    function void write_reg(logic idx, logic [12:0] data);
      if (idx == f12w_pkg::CFG_SECTOR_BYTES) sector_bytes = data;
      else sectors_per_cluster = data[7:0];
    endfunction

    // Emit the segment of the current cluster, then follow its table entry
    function segment_t walk_cluster();
      segment_t seg;
      logic [31:0] cb, span, pos;
      logic [63:0] addr;
      logic [15:0] pair;
      seg = '0;
      if (!in_chain(cur_cluster)) return seg;
      cb = cluster_size();
      addr = 64'(ROOT_END_SECTOR) * 64'(sector_bytes) + 64'(cb) * (64'(cur_cluster) - 64'd2);
      span = (cb < rem_bytes) ? cb : rem_bytes;
      if (span > 32'h000FFFFF) span = 32'h000FFFFF;
      pos = (32'(cur_cluster) * 32'd3) >> 1;
      pair = {fat_copy[(pos + 32'd1) % TABLE_BYTES], fat_copy[pos % TABLE_BYTES]};
      seg.valid = 1'b1;
      seg.addr = addr[31:0];
      seg.nbytes = span[19:0];
      seg.cluster = cur_cluster;
      seg.follow = cur_cluster[0] ? pair[15:4] : pair[11:0];
      seg.ends = !in_chain(seg.follow);
      rem_bytes = (rem_bytes > cb) ? rem_bytes - cb : 32'd0;
      cur_cluster = seg.follow;
      return seg;
    endfunction

    function void note_item(logic [1:0] act, logic [12:0] off, logic [7:0] val,
                            logic [11:0] first, logic [31:0] size);
      case (act)
        f12w_pkg::ACT_LOAD: fat_copy[off] = val;
        f12w_pkg::ACT_START: begin
          cur_cluster = first;
          rem_bytes = size;
        end
        f12w_pkg::ACT_STEP: expected_segments.push_back(walk_cluster());
        default: ;
      endcase
    endfunction

    function void check_segment(segment_t got);
      segment_t want;
      if (expected_segments.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected segment: v=%b addr=%h bytes=%h cl=%h next=%h last=%b",
                   got.valid, got.addr, got.nbytes, got.cluster, got.follow, got.ends);
        return;
      end
      want = expected_segments.pop_front();
      if (got.valid !== want.valid || got.addr !== want.addr || got.nbytes !== want.nbytes ||
          got.cluster !== want.cluster || got.follow !== want.follow || got.ends !== want.ends)
      begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("segment mismatch: expected v=%b addr=%h bytes=%h cl=%h next=%h last=%b",
                   want.valid, want.addr, want.nbytes, want.cluster, want.follow, want.ends);
          $display("                  actual   v=%b addr=%h bytes=%h cl=%h next=%h last=%b",
                   got.valid, got.addr, got.nbytes, got.cluster, got.follow, got.ends);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  action;
  logic [12:0] table_offset;
  logic [7:0]  table_byte;
  logic [11:0] start_cluster;
  logic [31:0] file_size;
  logic        cfg_write;
  logic        cfg_index;
  logic [12:0] cfg_data;
  logic        done;
  logic        segment_valid;
  logic [31:0] data_address;
  logic [19:0] segment_bytes;
  logic [11:0] this_cluster;
  logic [11:0] following_cluster;
  logic        last_segment;

  chain_scoreboard sb;
  segment_t        seen;
  bit              written [TABLE_BYTES];
  bit              burst;
  int              item_count;
  int              cycles;
  int              failures;

  fat12_cluster_chain_walker_core #(
    .TABLE_BYTES(TABLE_BYTES),
    .ROOT_END_SECTOR(ROOT_END_SECTOR)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .table_offset(table_offset),
    .table_byte(table_byte),
    .start_cluster(start_cluster),
    .file_size(file_size),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .segment_valid(segment_valid),
    .data_address(data_address),
    .segment_bytes(segment_bytes),
    .this_cluster(this_cluster),
    .following_cluster(following_cluster),
    .last_segment(last_segment)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst) begin
      if (done) begin
        seen.valid = segment_valid;
        seen.addr = data_address;
        seen.nbytes = segment_bytes;
        seen.cluster = this_cluster;
        seen.follow = following_cluster;
        seen.ends = last_segment;
        sb.check_segment(seen);
      end
      if (start && !busy)
        sb.note_item(action, table_offset, table_byte, start_cluster, file_size);
      if (cfg_write) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // All driving tasks are entered and left just after a falling edge
  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    if (burst || r < 55) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_item(logic [1:0] act, logic [12:0] off, logic [7:0] val,
                           logic [11:0] first, logic [31:0] size);
    action = act;
    table_offset = off;
    table_byte = val;
    start_cluster = first;
    file_size = size;
    start = 1'b1;
    // hold the item until the transfer edge
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (act == f12w_pkg::ACT_LOAD) written[off] = 1'b1;
    if (act != ACT_NONE) item_count++;
    idle_gap();
  endtask

  task automatic load_byte(logic [12:0] off, logic [7:0] val);
    send_item(f12w_pkg::ACT_LOAD, off, val, 12'($urandom), $urandom);
  endtask

  task automatic start_chain(logic [11:0] first, logic [31:0] size);
    send_item(f12w_pkg::ACT_START, 13'($urandom), 8'($urandom), first, size);
  endtask

  // Fill any never-loaded table byte the next step would read
  task automatic step_chain();
    logic [31:0] pos;
    int p;
    if (sb.in_chain(sb.cur_cluster)) begin
      pos = (32'(sb.cur_cluster) * 32'd3) >> 1;
      for (int k = 0; k < 2; k++) begin
        p = (pos + k) % TABLE_BYTES;
        if (!written[p]) load_byte(13'(p), 8'($urandom));
      end
    end
    send_item(f12w_pkg::ACT_STEP, 13'($urandom), 8'($urandom), 12'($urandom), $urandom);
  endtask

  // Rewrite one packed 12-bit entry, keeping the neighbor's nibble
  task automatic set_entry(logic [11:0] c, logic [11:0] val);
    logic [31:0] pos;
    logic [7:0] lo, hi;
    pos = (32'(c) * 32'd3) >> 1;
    lo = sb.fat_copy[pos];
    hi = sb.fat_copy[pos + 32'd1];
    if (c[0]) begin
      lo = {val[3:0], lo[3:0]};
      hi = val[11:4];
    end else begin
      lo = val[7:0];
      hi = {hi[7:4], val[11:8]};
    end
    load_byte(pos[12:0], lo);
    load_byte(pos[12:0] + 13'd1, hi);
  endtask

  function automatic logic [11:0] chain_end_code();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'd0;
    if (r == 1) return 12'd1;
    return 12'($urandom_range(f12w_pkg::CHAIN_END, 12'hFFF));
  endfunction

  task automatic random_chain();
    logic [11:0] path [8];
    logic [11:0] tail;
    logic [63:0] span;
    logic [31:0] size;
    int len;
    len = $urandom_range(1, 8);
    path[0] = 12'($urandom_range(2, f12w_pkg::CHAIN_END - 1));
    for (int i = 1; i < len; i++) begin
      // neighbors share a table byte, so favor them now and then
      if ($urandom_range(0, 3) == 0 && path[i-1] < f12w_pkg::CHAIN_END - 1)
        path[i] = path[i-1] + 12'd1;
      else path[i] = 12'($urandom_range(2, f12w_pkg::CHAIN_END - 1));
    end
    if ($urandom_range(0, 9) == 0) tail = path[$urandom_range(0, len - 1)];
    else tail = chain_end_code();
    for (int i = 0; i < len; i++) set_entry(path[i], (i == len - 1) ? tail : path[i+1]);
    span = 64'(sb.cluster_size()) * 64'(len + 1);
    if (span > 64'hFFFFFFFF) span = 64'hFFFFFFFF;
    case ($urandom_range(0, 7))
      0: size = 32'd0;
      1: size = 32'hFFFFFFFF;
      2, 3: size = $urandom;
      default: size = $urandom_range(0, span[31:0]);
    endcase
    start_chain(path[0], size);
    repeat (len + $urandom_range(0, 2)) step_chain();
  endtask

  task automatic random_noise();
    case ($urandom_range(0, 5))
      0, 1: load_byte(13'($urandom), 8'($urandom));
      2: send_item(ACT_NONE, 13'($urandom), 8'($urandom), 12'($urandom), $urandom);
      3: step_chain();
      default: begin
        start_chain(12'($urandom), $urandom);
        repeat ($urandom_range(0, 3)) step_chain();
      end
    endcase
  endtask

  task automatic random_phase(int quota);
    int goal;
    goal = item_count + quota;
    while (item_count < goal) begin
      burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 75) random_chain();
      else random_noise();
    end
    burst = 1'b0;
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.expected_segments.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [12:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic configure(logic [12:0] sec, logic [7:0] spc);
    drain();
    write_reg(f12w_pkg::CFG_SECTOR_BYTES, sec);
    write_reg(f12w_pkg::CFG_SECTORS_PER_CLUSTER, {5'b0, spc});
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    action = f12w_pkg::ACT_LOAD;
    table_offset = '0;
    table_byte = '0;
    start_cluster = '0;
    file_size = '0;
    cfg_write = 1'b0;
    cfg_index = f12w_pkg::CFG_SECTOR_BYTES;
    cfg_data = '0;
    burst = 1'b0;
    item_count = 0;
    cycles = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // no chain after reset: inactive segment
    step_chain();
    send_item(ACT_NONE, 13'h1FFF, 8'hFF, 12'hFFF, 32'hFFFFFFFF);
    load_byte(13'h1FFF, 8'hFF);
    load_byte(13'd0, 8'h00);
    // two-cluster chain: even entry then odd end entry
    set_entry(12'd2, 12'd3);
    set_entry(12'd3, 12'hFFF);
    start_chain(12'd2, 32'd700);
    repeat (3) step_chain();
    start_chain(12'd1, 32'hFFFFFFFF);
    step_chain();
    start_chain(f12w_pkg::CHAIN_END, 32'd100);
    step_chain();
    // highest live cluster whose entry is the cluster-one end marker
    set_entry(f12w_pkg::CHAIN_END - 12'd1, 12'd1);
    start_chain(f12w_pkg::CHAIN_END - 12'd1, 32'hFFFFFFFF);
    step_chain();
    start_chain(12'd2, 32'd0);
    step_chain();

    random_phase(160);
    configure(13'd1, 8'd1);
    random_phase(170);
    configure(13'd4096, 8'd128);
    random_phase(170);
    // cluster size beyond the 20-bit segment field
    configure(13'h1FFF, 8'hFF);
    random_phase(170);
    configure(13'($urandom), 8'($urandom));
    random_phase(170);
    configure(13'd512, 8'd1);
    random_phase(160);

    drain();
    failures = sb.mismatches + sb.expected_segments.size();
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
